/* sv/ltab_pkg.sv */
package ltab_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = 16;

  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int TAG_BITS   = KEY_BITS + 1;
  localparam int IN_KEY_BITS  = 32;
  localparam int OUT_CNT_BITS = 16;

  // Command codes.
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // Level codes.
  localparam logic LVL_ROW   = 1'b0;
  localparam logic LVL_TABLE = 1'b1;

  // Lock modes.
  localparam logic [2:0] MODE_S   = 3'd0;
  localparam logic [2:0] MODE_X   = 3'd1;
  localparam logic [2:0] MODE_IS  = 3'd2;
  localparam logic [2:0] MODE_IX  = 3'd3;
  localparam logic [2:0] MODE_SIX = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_GRANTED    = 3'd0;
  localparam logic [2:0] ST_CONFLICT   = 3'd1;
  localparam logic [2:0] ST_RELEASED   = 3'd2;
  localparam logic [2:0] ST_NOT_HELD   = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [2:0]            mode;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Bit r of the row for held mode h is set when requested mode r may join h.
  function automatic logic compatible(input logic [2:0] held, input logic [2:0] req);
    logic [4:0] row;
    row = 5'b00000;
    case (held)
      MODE_S:   row = 5'b00101;
      MODE_X:   row = 5'b00000;
      MODE_IS:  row = 5'b11101;
      MODE_IX:  row = 5'b01100;
      MODE_SIX: row = 5'b00100;
      default:  row = 5'b00000;
    endcase
    if (req > MODE_SIX) begin
      return 1'b0;
    end
    return row[req];
  endfunction

  // Brings the 32-bit key port to the stored key width.
  function automatic logic [KEY_BITS-1:0] key_of(input logic [IN_KEY_BITS-1:0] k);
    logic [KEY_BITS+IN_KEY_BITS-1:0] ext;
    ext = '0;
    ext[IN_KEY_BITS-1:0] = k;
    return ext[KEY_BITS-1:0];
  endfunction

  // Holder count as seen on the result port (low 16 bits).
  function automatic logic [OUT_CNT_BITS-1:0] out_count(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+OUT_CNT_BITS-1:0] ext;
    ext = '0;
    ext[COUNT_BITS-1:0] = c;
    return ext[OUT_CNT_BITS-1:0];
  endfunction

endpackage

/* sv/ltab_ram.sv */
module ltab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lock_table_engine.sv */
// Lock table engine: a non-blocking multigranularity lock manager.
// Requests arrive on the input channel (in_valid/in_ready) as one transaction
// each: command (lock/unlock), level (row/table), lock_key and mode. Every
// request yields exactly one result transaction on the output channel
// (out_valid/out_ready): status, holder_count and held_mode.
// Row and table keys share one table of ENTRIES slots held in a synchronous
// RAM; a valid bit per slot lives in flip-flops. A request is resolved by
// scanning the RAM one slot per cycle, reads pipelined through the RAM's
// registered read port, stopping early at the matching slot. A miss (new
// key, unlock of an absent key) scans all slots. One request is in flight
// at a time: the next is accepted only once the last one's decision is done.
// Reset clears all valid bits at once, so the table is empty straight away
// and no clearing pass is needed. When the receiver stalls, the result is
// held in the output register; the next request may still be accepted and
// scanned, and it waits at its decision step until the register frees.
module lock_table_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic        level,
  input  logic [31:0] lock_key,
  input  logic [2:0]  mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] holder_count,
  output logic [2:0]  held_mode
);
  import ltab_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  localparam logic [IDX_BITS:0]     SCAN_END = (IDX_BITS + 1)'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  state_t state;

  // Latched request.
  logic                  req_cmd;
  logic                  req_lvl;
  logic [TAG_BITS-1:0]   req_tag;
  logic [2:0]            req_mode;

  // Scan bookkeeping: issue counter, read in flight, free slot found.
  logic [IDX_BITS:0]     issue_idx;
  logic                  pend;
  logic [IDX_BITS-1:0]   pend_idx;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;

  // Outcome of the scan.
  logic                  hit;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [2:0]            e_mode;
  logic [COUNT_BITS-1:0] e_cnt;

  logic [ENTRIES-1:0]    valid;

  // RAM ports.
  logic                  ram_we;
  logic [IDX_BITS-1:0]   ram_raddr;
  entry_t                rd_entry;
  logic [ENTRY_BITS-1:0] rd_data;

  // Decision logic.
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  entry_t                wr_entry;
  logic                  set_valid;
  logic                  clr_valid;
  logic [2:0]            res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic [2:0]            res_mode;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  grant_ok;
  logic                  fire;
  logic                  scan_hit;
  logic                  issuing;

  assign in_ready  = (state == S_IDLE);
  assign ram_raddr = issue_idx[IDX_BITS-1:0];
  assign rd_entry  = rd_data;
  assign issuing   = (state == S_SCAN) && (issue_idx != SCAN_END);

  // The read returned this cycle belongs to the slot issued in the last one.
  assign scan_hit = (state == S_SCAN) && pend && valid[pend_idx]
                    && (rd_entry.tag == req_tag);

  // A decision completes only when the output register can take the result.
  assign fire   = (state == S_DECIDE) && (!out_valid || out_ready);
  assign ram_we = fire && wr_en;

  ltab_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    cnt_dec = (e_cnt != '0) ? (e_cnt - CNT_ONE) : '0;
    cnt_inc = (e_cnt == CNT_MAX) ? e_cnt : (e_cnt + CNT_ONE);
    if (req_lvl == LVL_ROW) begin
      grant_ok = (e_mode == MODE_S) && (req_mode == MODE_S);
    end else begin
      grant_ok = compatible(e_mode, req_mode);
    end

    wr_en          = 1'b0;
    wr_addr        = hit_idx;
    wr_entry.tag   = req_tag;
    wr_entry.mode  = e_mode;
    wr_entry.count = e_cnt;
    set_valid      = 1'b0;
    clr_valid      = 1'b0;
    res_status     = ST_CONFLICT;
    res_count      = '0;
    res_mode       = 3'd0;

    if (req_cmd == CMD_UNLOCK) begin
      if (!hit) begin
        res_status = ST_NOT_HELD;
      end else begin
        wr_en          = 1'b1;
        wr_entry.count = cnt_dec;
        clr_valid      = (cnt_dec == '0);
        res_status     = ST_RELEASED;
        res_count      = cnt_dec;
        res_mode       = e_mode;
      end
    end else if (!hit) begin
      // A new key: an undefined mode is refused before a slot is taken.
      if (req_mode > MODE_SIX) begin
        res_status = ST_CONFLICT;
      end else if (!free_found) begin
        res_status = ST_TABLE_FULL;
      end else begin
        wr_en          = 1'b1;
        wr_addr        = free_idx;
        wr_entry.mode  = req_mode;
        wr_entry.count = CNT_ONE;
        set_valid      = 1'b1;
        res_status     = ST_GRANTED;
        res_count      = CNT_ONE;
        res_mode       = req_mode;
      end
    end else if (grant_ok) begin
      // The stored mode is kept; only the count moves, saturating at the top.
      wr_en          = 1'b1;
      wr_entry.count = cnt_inc;
      res_status     = ST_GRANTED;
      res_count      = cnt_inc;
      res_mode       = e_mode;
    end else begin
      res_status = ST_CONFLICT;
      res_count  = e_cnt;
      res_mode   = e_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      valid      <= '0;
      pend       <= 1'b0;
      issue_idx  <= '0;
      free_found <= 1'b0;
      hit        <= 1'b0;
    end else begin
      // A new result loaded in the same cycle keeps the register full.
      if (out_valid && out_ready && !fire) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_cmd    <= command;
            req_lvl    <= level;
            req_tag    <= {level, key_of(lock_key)};
            req_mode   <= mode;
            issue_idx  <= '0;
            pend       <= 1'b0;
            free_found <= 1'b0;
            hit        <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          pend     <= issuing;
          pend_idx <= ram_raddr;
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
            if (!free_found && !valid[ram_raddr]) begin
              free_found <= 1'b1;
              free_idx   <= ram_raddr;
            end
          end
          if (scan_hit) begin
            hit     <= 1'b1;
            hit_idx <= pend_idx;
            e_mode  <= rd_entry.mode;
            e_cnt   <= rd_entry.count;
            state   <= S_DECIDE;
          end else if (!pend && !issuing) begin
            // Every slot has been examined without a match.
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (fire) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            holder_count <= out_count(res_count);
            held_mode    <= res_mode;
            if (set_valid) begin
              valid[wr_addr] <= 1'b1;
            end
            if (clr_valid) begin
              valid[wr_addr] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A grant always leaves at least one holder on the entry.
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_GRANTED) |-> (holder_count != 16'd0))
    else $error("granted result with zero holder count");

  // A new entry is only ever written into a slot that was free.
  a_new_slot_free: assert property (@(posedge clk) disable iff (rst)
    (ram_we && set_valid) |-> !valid[wr_addr])
    else $error("new entry written over a valid slot");

  // The scan counter never runs past the end of the table.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_idx <= SCAN_END))
    else $error("scan counter beyond table size");

  // A result is only produced from a completed decision.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DECIDE))
    else $error("result raised outside the decision step");
`endif

endmodule

/* tb/sv/lock_table_engine_tb.sv */
`timescale 1ns / 100ps

import ltab_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [15:0] count;
  logic [2:0]  held;
} lock_reply_t;

class lock_scoreboard;
  bit                    used   [ENTRIES];
  logic [TAG_BITS-1:0]   tags   [ENTRIES];
  logic [2:0]            modes  [ENTRIES];
  logic [COUNT_BITS-1:0] counts [ENTRIES];
  lock_reply_t           replies_due[$];
  int                    mismatches;

  // Table-level compatibility of a requested mode with the held mode.
  static function bit may_join(logic [2:0] held, logic [2:0] req);
    case (held)
      MODE_S:   return req == MODE_S || req == MODE_IS;
      MODE_IS:  return req != MODE_X;
      MODE_IX:  return req == MODE_IS || req == MODE_IX;
      MODE_SIX: return req == MODE_IS;
      default:  return 1'b0;
    endcase
  endfunction

  function void note_mismatch(string what, lock_reply_t want, lock_reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d count %0d mode %0d, got status %0d count %0d mode %0d",
               $realtime, what, want.status, want.count, want.held,
               got.status, got.count, got.held);
    end
  endfunction

  // Works out the reply to an accepted request and updates the lock table.
  function void note_input(logic c, logic l, logic [31:0] k, logic [2:0] m);
    logic [TAG_BITS-1:0] tag;
    int                  hit;
    int                  spare;
    lock_reply_t         r;
    tag   = {l, k[KEY_BITS-1:0]};
    hit   = -1;
    spare = -1;
    r     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (used[i]) begin
        if (hit < 0 && tags[i] == tag) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (c == CMD_UNLOCK) begin
      if (hit < 0) begin
        r.status = ST_NOT_HELD;
      end else begin
        if (counts[hit] != '0) counts[hit]--;
        if (counts[hit] == '0) used[hit] = 1'b0;
        r = '{ST_RELEASED, 16'(counts[hit]), modes[hit]};
      end
    end else if (hit < 0) begin
      if (m > MODE_SIX) begin
        r.status = ST_CONFLICT;
      end else if (spare < 0) begin
        r.status = ST_TABLE_FULL;
      end else begin
        used[spare]   = 1'b1;
        tags[spare]   = tag;
        modes[spare]  = m;
        counts[spare] = COUNT_BITS'(1);
        r = '{ST_GRANTED, 16'd1, m};
      end
    end else begin
      if (m <= MODE_SIX && (l == LVL_ROW ? (modes[hit] == MODE_S && m == MODE_S)
                                         : may_join(modes[hit], m))) begin
        if (counts[hit] != {COUNT_BITS{1'b1}}) counts[hit]++;
        r.status = ST_GRANTED;
      end else begin
        r.status = ST_CONFLICT;
      end
      r.count = 16'(counts[hit]);
      r.held  = modes[hit];
    end
    replies_due = {replies_due, r};
  endfunction

  function void check_result(logic [2:0] st, logic [15:0] cnt, logic [2:0] hm);
    lock_reply_t want;
    lock_reply_t got;
    got = '{st, cnt, hm};
    if (replies_due.size() == 0) begin
      note_mismatch("result with nothing outstanding", '0, got);
      return;
    end
    want = replies_due.pop_front();
    if (want.status !== st || want.count !== cnt || want.held !== hm)
      note_mismatch("result mismatch", want, got);
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  function int held_entries();
    int n;
    n = 0;
    foreach (used[i]) n += used[i];
    return n;
  endfunction

  // Replaces level and key by those of a randomly chosen held entry, if any.
  function void pick_held_key(inout logic l, inout logic [31:0] k);
    int n;
    n = held_entries();
    if (n == 0) return;
    n = $urandom_range(n - 1);
    foreach (used[i]) begin
      if (used[i]) begin
        if (n == 0) begin
          l = tags[i][KEY_BITS];
          k = 32'(tags[i][KEY_BITS-1:0]);
          return;
        end
        n--;
      end
    end
  endfunction

  function void close();
    if (replies_due.size() != 0) begin
      mismatches += replies_due.size();
      $display("%0d replies never arrived", replies_due.size());
    end
  endfunction
endclass

module lock_table_engine_tb;

  // A miss scans every slot, so this is the longest the block works on one
  // request; it bounds the settling time before the final verdict.
  localparam int SCAN_CYCLES    = ENTRIES + 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_KEYS      = 96;
  localparam int PHASE_ITEMS    = 425;
  localparam int FILL_ITEMS     = 250;

  // Idling plan of the random phases: none, sender only, receiver only, both.
  localparam int SEND_GAP_PCT   [4] = '{0, 57, 0, 25};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 57, 25};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_LOCK;
  logic        level = LVL_ROW;
  logic [31:0] lock_key = '0;
  logic [2:0]  mode = MODE_S;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] holder_count;
  logic [2:0]  held_mode;

  lock_scoreboard sb = new();

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_requests  = 0;
  int          hold_served    = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;
  logic [31:0] key_pool [POOL_KEYS];

  always #2 clk = ~clk;

  lock_table_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .level        (level),
    .lock_key     (lock_key),
    .mode         (mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .holder_count (holder_count),
    .held_mode    (held_mode)
  );

  // Result side. The outputs are sampled at the rising edge, before the
  // block's own updates for that edge land, so a transaction seen here is
  // exactly the one accepted at this edge. A hold-off request from the
  // stimulus makes the receiver refuse results for a long stretch, which
  // lets the block fill its output register and then stall its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(status, holder_count, held_mode);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // The watchdog counts cycles in which no transaction completes on either
  // channel; a correct block never goes quiet for anything like this long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // is left high on return: the next call either replaces the payload in the
  // same step or lowers valid for an idle gap, so no transaction repeats.
  task automatic send_item(input logic c, input logic l, input logic [31:0] k,
                           input logic [2:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    level    <= l;
    lock_key <= k;
    mode     <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(c, l, k, m);
  endtask

  // Stops offering and waits until every outstanding reply has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random request. Most of them work on a small pool of keys, and most
  // unlocks target keys that are actually held, so that entries are shared,
  // released and the table runs full; the rest is noise (fresh keys, illegal
  // modes, unlocks of absent keys).
  task automatic random_item(input int lock_pct);
    logic        c;
    logic        l;
    logic [31:0] k;
    logic [2:0]  m;
    c = ($urandom_range(99) < lock_pct) ? CMD_LOCK : CMD_UNLOCK;
    l = 1'($urandom_range(1));
    k = key_pool[$urandom_range(POOL_KEYS - 1)];
    if (c == CMD_UNLOCK && $urandom_range(99) < 80) sb.pick_held_key(l, k);
    if ($urandom_range(99) < 4) k = $urandom();
    if ($urandom_range(99) < 6) m = 3'($urandom_range(7, 5));
    else m = 3'($urandom_range(4));
    if (c == CMD_LOCK && l == LVL_ROW && $urandom_range(99) < 50) m = MODE_S;
    send_item(c, l, k, m);
  endtask

  initial begin
    logic [31:0] last_key;
    logic        l;
    logic [31:0] k;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: shared and exclusive row locks, the compatibility
    // matrix at table level, the same key in both key spaces, illegal modes
    // on new and held keys, release down to zero and unlock of absent keys.
    send_item(CMD_UNLOCK, LVL_ROW,   32'h0,        MODE_S);
    send_item(CMD_LOCK,   LVL_ROW,   32'h0,        MODE_S);
    send_item(CMD_LOCK,   LVL_ROW,   32'h0,        MODE_S);
    send_item(CMD_LOCK,   LVL_ROW,   32'h0,        MODE_X);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h0,        MODE_IS);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h0,        MODE_IX);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h0,        MODE_X);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h0,        3'd7);
    send_item(CMD_LOCK,   LVL_ROW,   32'hFFFFFFFF, 3'd5);
    send_item(CMD_LOCK,   LVL_ROW,   32'hFFFFFFFF, MODE_X);
    send_item(CMD_LOCK,   LVL_ROW,   32'hFFFFFFFF, MODE_X);
    send_item(CMD_LOCK,   LVL_TABLE, 32'hFFFFFFFF, MODE_SIX);
    send_item(CMD_LOCK,   LVL_TABLE, 32'hFFFFFFFF, MODE_IS);
    send_item(CMD_LOCK,   LVL_TABLE, 32'hFFFFFFFF, MODE_S);
    send_item(CMD_LOCK,   LVL_TABLE, 32'hA5A5A5A5, MODE_X);
    send_item(CMD_LOCK,   LVL_TABLE, 32'hA5A5A5A5, MODE_IS);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h5A5A5A5A, MODE_S);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h5A5A5A5A, MODE_S);
    send_item(CMD_LOCK,   LVL_TABLE, 32'h5A5A5A5A, MODE_IS);
    send_item(CMD_UNLOCK, LVL_ROW,   32'h0,        3'd6);
    send_item(CMD_UNLOCK, LVL_ROW,   32'h0,        MODE_X);
    send_item(CMD_UNLOCK, LVL_ROW,   32'h0,        MODE_S);
    send_item(CMD_LOCK,   LVL_ROW,   32'h0,        MODE_IX);
    send_item(CMD_LOCK,   LVL_ROW,   32'h0,        MODE_IX);

    // The sender pauses here until every reply has been returned.
    wait_idle();

    // Random phases, each with its own idling plan. Each phase first leans
    // towards locking so the table runs full, then towards unlocking so it
    // drains again. A long receiver hold-off is requested twice.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_GAP_PCT[p];
      recv_stall_pct <= RECV_STALL_PCT[p];
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFFFFFF;
      for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 120 && (p == 0 || p == 3)) hold_requests <= hold_requests + 1;
        random_item(i < FILL_ITEMS ? 70 : 30);
      end
      wait_idle();
    end

    // Empty the table, then share one row lock a few times, try an
    // exclusive lock on it and release once.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    while (sb.held_entries() > 0) begin
      l = LVL_ROW;
      k = '0;
      sb.pick_held_key(l, k);
      send_item(CMD_UNLOCK, l, k, MODE_S);
    end
    wait_idle();
    last_key = $urandom();
    repeat (4) send_item(CMD_LOCK, LVL_ROW, last_key, MODE_S);
    send_item(CMD_LOCK, LVL_ROW, last_key, MODE_X);
    send_item(CMD_UNLOCK, LVL_ROW, last_key, MODE_S);

    // Let any stray result show itself before the verdict.
    wait_idle();
    repeat (SCAN_CYCLES) @(posedge clk);
    sb.close();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
